[sv/flb_pkg.sv]
// Shared types, codes and the lg2(1+2^-k) table for the base-2 logarithm pipeline.
package flb_pkg;

	localparam logic [4:0] FRAC_MIN   = 5'd4;
	localparam logic [4:0] FRAC_MAX   = 5'd28;
	localparam logic [4:0] FRAC_RESET = 5'd16;

	// Item class, decided at the front and carried to the end
	localparam logic [1:0] CODE_NORMAL  = 2'd0;
	localparam logic [1:0] CODE_UNDEF   = 2'd1;
	localparam logic [1:0] CODE_NEG_INF = 2'd2;
	localparam logic [1:0] CODE_POS_INF = 2'd3;

	localparam logic [31:0] SENT_UNDEF   = 32'h8000_0000;
	localparam logic [31:0] SENT_POS_INF = 32'h7FFF_FFFF;
	localparam logic [31:0] SENT_NEG_INF = 32'h8000_0001;

	localparam logic [62:0] X_ONE = 63'h4000_0000_0000_0000;

	localparam int TABLE_DEPTH = 36;

	// lg2(1 + 2^-k): one whole bit, 63 fraction bits
	localparam logic [63:0] LG_TABLE [0:TABLE_DEPTH-1] = '{
		64'h8000000000000000, 64'h4AE00D1CFDEB4400, 64'h2934F0979A371600,
		64'h15C01A39FBD68800, 64'h0B31FB7D64898B00, 64'h05AEB4DD63BF61C0,
		64'h02DCF2D0B85A4540, 64'h016FE50B6EF08510, 64'h00B84E236BD563B8,
		64'h005C3E0FFC29D594, 64'h002E24CA6E87E8A8, 64'h001713D62F7957C3,
		64'h000B8A476150DFE4, 64'h0005C53AC47E94D8, 64'h0002E2A32762FA6B,
		64'h0001715305002E4A, 64'h0000B8A9DED47C11, 64'h00005C55067F6E58,
		64'h00002E2A89050622, 64'h0000171545F3D72B, 64'h00000B8AA35640A7,
		64'h000005C551C23599, 64'h000002E2A8E6E01E, 64'h000001715474E163,
		64'h000000B8AA3ACD06, 64'h0000005C551D7D98, 64'h0000002E2A8EC491,
		64'h00000017154763BA, 64'h0000000B8AA3B239, 64'h00000005C551D933,
		64'h00000002E2A8EC9F, 64'h0000000171547651, 64'h00000000B8AA3B28,
		64'h000000005C551D94, 64'h000000002E2A8ECA, 64'h0000000017154765
	};

	typedef struct packed {
		logic [1:0]        code;
		logic signed [6:0] whole;
		logic [62:0]       arg;
		logic [62:0]       x;
		logic [63:0]       mant;
	} pipe_t;

endpackage

[sv/flb_norm.sv]
// Front stages: classify the operand, find its bit length, normalize to [1,2).
module flb_norm (
	input  logic               clk,
	input  logic               en_s1,
	input  logic               en_s2,
	input  logic [4:0]         frac_bits,
	input  logic signed [31:0] operand,
	output flb_pkg::pipe_t     pipe_s2
);
	import flb_pkg::*;

	logic [30:0] op_s1;
	logic [4:0]  nb_s1;
	logic [1:0]  code_s1;
	logic [4:0]  nb;
	logic [1:0]  code;
	logic [5:0]  shamt;
	pipe_t       nxt;

	always_comb begin
		nb = 5'd0;
		for (int i = 0; i < 31; i++) begin
			if (operand[i]) begin
				nb = 5'(i + 1);
			end
		end
		if (operand[31]) begin
			code = CODE_UNDEF;
		end else if (operand == 32'sd0) begin
			code = CODE_NEG_INF;
		end else if (operand == $signed(SENT_POS_INF)) begin
			code = CODE_POS_INF;
		end else begin
			code = CODE_NORMAL;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1   <= operand[30:0];
			nb_s1   <= nb;
			code_s1 <= code;
		end
	end

	always_comb begin
		shamt      = 6'd63 - {1'b0, nb_s1};
		nxt.code   = code_s1;
		nxt.whole  = $signed({2'b00, nb_s1}) - $signed({2'b00, frac_bits}) - 7'sd1;
		nxt.arg    = {32'd0, op_s1} << shamt;
		nxt.x      = X_ONE;
		nxt.mant   = 64'd0;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			pipe_s2 <= nxt;
		end
	end

endmodule

[sv/flb_step.sv]
// One BKM L-mode shift-add-compare step with its pipeline register.
module flb_step #(
	parameter int K = 1
) (
	input  logic           clk,
	input  logic           en,
	input  flb_pkg::pipe_t pipe_in,
	output flb_pkg::pipe_t pipe_s1
);
	import flb_pkg::*;

	logic [63:0] z;
	pipe_t       nxt;

	always_comb begin
		z   = {1'b0, pipe_in.x} + {1'b0, pipe_in.x >> K};
		nxt = pipe_in;
		// take the factor (1 + 2^-K) when it does not overshoot the argument
		if (z <= {1'b0, pipe_in.arg}) begin
			nxt.x    = z[62:0];
			nxt.mant = pipe_in.mant + LG_TABLE[K];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s1 <= nxt;
		end
	end

endmodule

[sv/flb_round.sv]
// Back stages: round the mantissa to frac_bits and compose the fixed-point result.
module flb_round (
	input  logic               clk,
	input  logic               en_s1,
	input  logic               en_s2,
	input  logic [4:0]         frac_bits,
	input  flb_pkg::pipe_t     pipe_in,
	output logic signed [31:0] result_s2
);
	import flb_pkg::*;

	logic [5:0]        shamt;
	logic [63:0]       t;
	logic [30:0]       m;
	logic [30:0]       m_s1;
	logic signed [6:0] whole_s1;
	logic [1:0]        code_s1;
	logic [7:0]        lim;
	logic signed [7:0] wmin;
	logic signed [7:0] w8;
	logic [31:0]       wfix;
	logic [31:0]       r;
	logic [31:0]       res;

	always_comb begin
		// keep one bit below the last kept fraction bit for round half up
		shamt = 6'd62 - {1'b0, frac_bits};
		t     = pipe_in.mant >> shamt;
		m     = {1'b0, t[30:1]} + {30'd0, t[0]};
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			m_s1     <= m;
			whole_s1 <= pipe_in.whole;
			code_s1  <= pipe_in.code;
		end
	end

	always_comb begin
		lim  = (frac_bits >= 5'd26) ? (8'd1 << (5'd31 - frac_bits)) : 8'd64;
		wmin = 8'sd0 - $signed(lim);
		w8   = {whole_s1[6], whole_s1};
		wfix = {{25{whole_s1[6]}}, whole_s1} << frac_bits;
		r    = wfix + {1'b0, m_s1};
		case (code_s1)
			CODE_UNDEF:   res = SENT_UNDEF;
			CODE_NEG_INF: res = SENT_NEG_INF;
			CODE_POS_INF: res = SENT_POS_INF;
			default: begin
				if (w8 < wmin) begin
					if ((w8 == wmin - 8'sd1) && (m_s1 != 31'd0)) begin
						res = SENT_UNDEF + {1'b0, m_s1};
					end else begin
						res = SENT_NEG_INF;
					end
				end else begin
					res = r;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			result_s2 <= $signed(res);
		end
	end

endmodule

[sv/fixed_point_log2_bkm.sv]
// Top level: base-2 logarithm of a signed fixed-point value, BKM L-mode pipeline.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid / in_ready       operand
//   output    out        out_valid / out_ready     log_result
//   config    in         cfg_wr_en                 cfg_wr_data (frac_bits)
//
// The pipeline has two normalize stages, one stage per BKM step and
// two rounding stages. One item enters per cycle when the output is taken.
// Reset clears the stage valid bits and sets frac_bits to 16.
// Each stage holds while the stage after it is full and stalled; an empty stage
// still fills, so input is taken while a result waits at the output.
module fixed_point_log2_bkm #(
	parameter int ITERATIONS = 35
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] operand,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] log_result,
	input  logic               cfg_wr_en,
	input  logic [4:0]         cfg_wr_data
);
	import flb_pkg::*;

	localparam int NSTAGE = ITERATIONS + 4;

	logic [4:0]        frac_bits_q;
	logic [NSTAGE-1:0] valid_q;
	logic [NSTAGE-1:0] adv;
	pipe_t             pipe [0:ITERATIONS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_bits_q <= FRAC_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_wr_data < FRAC_MIN) begin
				frac_bits_q <= FRAC_MIN;
			end else if (cfg_wr_data > FRAC_MAX) begin
				frac_bits_q <= FRAC_MAX;
			end else begin
				frac_bits_q <= cfg_wr_data;
			end
		end
	end

	// a stage advances when it is empty or the stage after it advances
	always_comb begin
		adv[NSTAGE-1] = !valid_q[NSTAGE-1] || out_ready;
		for (int i = NSTAGE - 2; i >= 0; i--) begin
			adv[i] = !valid_q[i] || adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int i = 1; i < NSTAGE; i++) begin
				if (adv[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = valid_q[NSTAGE-1];

	flb_norm u_norm (
		.clk       (clk),
		.en_s1     (adv[0]),
		.en_s2     (adv[1]),
		.frac_bits (frac_bits_q),
		.operand   (operand),
		.pipe_s2   (pipe[0])
	);

	for (genvar k = 1; k <= ITERATIONS; k++) begin : g_step
		flb_step #(
			.K (k)
		) u_step (
			.clk     (clk),
			.en      (adv[k+1]),
			.pipe_in (pipe[k-1]),
			.pipe_s1 (pipe[k])
		);
	end

	flb_round u_round (
		.clk       (clk),
		.en_s1     (adv[NSTAGE-2]),
		.en_s2     (adv[NSTAGE-1]),
		.frac_bits (frac_bits_q),
		.pipe_in   (pipe[ITERATIONS]),
		.result_s2 (log_result)
	);

endmodule

[sim/testbench.sv]
// Self-checking bench for the fixed-point base-2 logarithm pipeline: directed and random operands.
module testbench;
	import flb_pkg::*;

	localparam int STEPS      = 35;
	localparam int LATENCY    = STEPS + 4;
	localparam int PHASE_LEN  = 250;
	localparam int N_PHASES   = 8;
	localparam int HOLD_LEN   = 300;
	localparam int CALM_LEN   = 200;
	localparam int MAX_CYCLES = 200000;

	// lg2(1 + 2^-k), one whole bit and 63 fraction bits
	localparam logic [63:0] LG2_STEP [0:35] = '{
		64'h8000000000000000, 64'h4AE00D1CFDEB4400, 64'h2934F0979A371600,
		64'h15C01A39FBD68800, 64'h0B31FB7D64898B00, 64'h05AEB4DD63BF61C0,
		64'h02DCF2D0B85A4540, 64'h016FE50B6EF08510, 64'h00B84E236BD563B8,
		64'h005C3E0FFC29D594, 64'h002E24CA6E87E8A8, 64'h001713D62F7957C3,
		64'h000B8A476150DFE4, 64'h0005C53AC47E94D8, 64'h0002E2A32762FA6B,
		64'h0001715305002E4A, 64'h0000B8A9DED47C11, 64'h00005C55067F6E58,
		64'h00002E2A89050622, 64'h0000171545F3D72B, 64'h00000B8AA35640A7,
		64'h000005C551C23599, 64'h000002E2A8E6E01E, 64'h000001715474E163,
		64'h000000B8AA3ACD06, 64'h0000005C551D7D98, 64'h0000002E2A8EC491,
		64'h00000017154763BA, 64'h0000000B8AA3B239, 64'h00000005C551D933,
		64'h00000002E2A8EC9F, 64'h0000000171547651, 64'h00000000B8AA3B28,
		64'h000000005C551D94, 64'h000000002E2A8ECA, 64'h0000000017154765
	};

	typedef struct {
		logic        is_fmt;
		logic [31:0] value;
	} plan_t;

	typedef struct {
		logic [31:0] arg;
		logic [4:0]  fb;
		logic [31:0] lg;
	} lg_due_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] operand = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] log_result;
	logic               cfg_wr_en = 1'b0;
	logic [4:0]         cfg_wr_data = '0;

	plan_t   operand_plan [$];
	lg_due_t lg2_due [$];
	logic [4:0] fmt_bits = FRAC_RESET;
	logic    in_xfer = 1'b0;
	logic    calm;
	int      cycle_cnt = 0;
	int      in_count = 0;
	int      out_count = 0;
	int      fmt_writes = 0;
	int      miss_cnt = 0;
	int      n_items = 0;
	int      hold_at = 32'h7FFF_FFFF;
	int      calm_lo = 32'h7FFF_FFFF;
	int      stall_left = 0;
	logic    long_done = 1'b0;

	fixed_point_log2_bkm #(
		.ITERATIONS(STEPS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operand    (operand),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.log_result (log_result),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	assign calm = (in_count >= calm_lo) && (in_count < calm_lo + CALM_LEN);

	function automatic logic [31:0] lg2_fixed(logic [31:0] op, logic [4:0] f);
		logic [63:0] arg, x, z, mant, m;
		int          nb, fi, w, whole_min, sh, i, k;
		longint      r;
		if (op[31])
			return SENT_UNDEF;
		if (op == 32'd0)
			return SENT_NEG_INF;
		if (op == SENT_POS_INF)
			return SENT_POS_INF;
		nb = 0;
		for (i = 0; i < 32; i++)
			if (op[i])
				nb = i + 1;
		fi = f;
		w = nb - fi - 1;
		arg = {32'd0, op} << (63 - nb);
		x = 64'h4000_0000_0000_0000;
		mant = '0;
		for (k = 1; k <= STEPS && k < 36; k++) begin
			z = x + (x >> k);
			if (z <= arg) begin
				x = z;
				mant = mant + LG2_STEP[k];
			end
		end
		// round half up to fi fraction bits
		sh = 63 - fi;
		m = (mant >> sh) + ((mant >> (sh - 1)) & 64'd1);
		whole_min = -(1 << (31 - fi));
		if (w < whole_min) begin
			if (w == whole_min - 1 && m != 0)
				return 32'h8000_0000 + m[31:0];
			return SENT_NEG_INF;
		end
		r = longint'(w) * (longint'(1) << fi) + longint'(m);
		return r[31:0];
	endfunction

	function automatic logic [31:0] rand_operand();
		int          sel, nb;
		logic [31:0] v;
		sel = $urandom_range(99);
		if (sel < 6) begin
			v = 32'h8000_0000 | $urandom;
		end else if (sel < 8) begin
			v = '0;
		end else if (sel < 10) begin
			v = SENT_POS_INF;
		end else begin
			// spread over bit lengths; some powers of two, some all ones below the top bit
			nb = $urandom_range(31, 1);
			v = $urandom;
			case ($urandom_range(7))
				0: v = '0;
				1: v = '1;
				default: ;
			endcase
			v = (v & ((32'd1 << (nb - 1)) - 32'd1)) | (32'd1 << (nb - 1));
		end
		return v;
	endfunction

	task automatic plan_op(logic [31:0] v);
		plan_t p;
		p.is_fmt = 1'b0;
		p.value = v;
		operand_plan.push_back(p);
		n_items++;
	endtask

	task automatic plan_fmt(logic [4:0] v);
		plan_t p;
		p.is_fmt = 1'b1;
		p.value = {27'd0, v};
		operand_plan.push_back(p);
	endtask

	task automatic flag(string msg);
		miss_cnt++;
		if (miss_cnt <= 10)
			$display("%s", msg);
	endtask

	// Driver: hold valid until transfer; format writes only once the pipeline is drained
	always @(negedge clk) begin
		logic       nv, nc;
		logic [31:0] nop;
		logic [4:0] ncd;
		plan_t      head;
		if (arst_n) begin
			nv = in_valid && !in_xfer;
			nc = 1'b0;
			nop = operand;
			ncd = cfg_wr_data;
			if (!nv && operand_plan.size() != 0) begin
				head = operand_plan[0];
				if (head.is_fmt) begin
					if (lg2_due.size() == 0) begin
						nc = 1'b1;
						ncd = head.value[4:0];
						void'(operand_plan.pop_front());
					end
				end else if (calm || $urandom_range(99) >= 9) begin
					nv = 1'b1;
					nop = head.value;
					void'(operand_plan.pop_front());
				end
			end
			in_valid <= nv;
			operand <= nop;
			cfg_wr_en <= nc;
			cfg_wr_data <= ncd;
		end
	end

	// Receiver: one long hold-off mid-phase, otherwise random stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left == 0 && !long_done && in_count >= hold_at) begin
				stall_left = HOLD_LEN;
				long_done = 1'b1;
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || $urandom_range(99) >= 9;
			end
		end
	end

	// Monitor: predict on input transfer, compare on output transfer
	always @(posedge clk) begin
		lg_due_t want;
		cycle_cnt++;
		in_xfer = 1'b0;
		if (arst_n) begin
			if (cfg_wr_en) begin
				fmt_writes++;
				if (cfg_wr_data < FRAC_MIN)
					fmt_bits = FRAC_MIN;
				else if (cfg_wr_data > FRAC_MAX)
					fmt_bits = FRAC_MAX;
				else
					fmt_bits = cfg_wr_data;
			end
			in_xfer = in_valid && in_ready;
			if (in_xfer) begin
				want.arg = operand;
				want.fb = fmt_bits;
				want.lg = lg2_fixed(operand, fmt_bits);
				lg2_due.push_back(want);
				in_count++;
			end
			if (out_valid && out_ready) begin
				out_count++;
				if (lg2_due.size() == 0) begin
					flag($sformatf("unexpected result %h", log_result));
				end else begin
					want = lg2_due.pop_front();
					if (log_result !== want.lg)
						flag($sformatf("lg2 of %h at frac_bits %0d: want %h got %h",
							want.arg, want.fb, want.lg, log_result));
				end
			end
		end
	end

	initial begin
		while (cycle_cnt < MAX_CYCLES)
			@(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int ph, i;
		arst_n = 1'b0;

		// reset format, 16 fraction bits: sentinels, extremes, rounding carry
		plan_op(32'h8000_0000);
		plan_op(32'hFFFF_FFFF);
		plan_op(32'h0000_0000);
		plan_op(32'h7FFF_FFFF);
		plan_op(32'h7FFF_FFFE);
		plan_op(32'h0000_0001);
		plan_op(32'h0001_0000);
		plan_op(32'h0002_0000);
		plan_op(32'h0001_8000);
		plan_op(32'h0001_FFFF);
		plan_op(32'h0000_8000);
		// below the minimum, saturates to 4
		plan_fmt(5'd0);
		plan_op(32'h0000_0001);
		plan_op(32'h7FFF_FFFE);
		plan_op(32'h0000_0010);
		// above the maximum, saturates to 28: one below the whole minimum, further below, and in range
		plan_fmt(5'd31);
		plan_op(32'h0008_0000);
		plan_op(32'h000F_FFFF);
		plan_op(32'h000C_0000);
		plan_op(32'h0000_1234);
		plan_op(32'h0010_0000);
		plan_op(32'h1000_0000);
		plan_fmt(5'd27);
		plan_op(32'h0000_0600);
		plan_op(32'h0000_0400);
		plan_op(32'h0000_0200);

		hold_at = n_items + PHASE_LEN + 100;
		calm_lo = n_items + 4 * PHASE_LEN + 20;
		for (ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: plan_fmt(FRAC_MIN);
				1: plan_fmt(FRAC_MAX);
				2: plan_fmt(5'd1);
				3: plan_fmt(5'd30);
				4: plan_fmt(FRAC_RESET);
				5: plan_fmt(5'd27);
				6: plan_fmt(5'd8);
				default: plan_fmt(5'($urandom_range(31)));
			endcase
			for (i = 0; i < PHASE_LEN; i++)
				plan_op(rand_operand());
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		while (in_count < n_items || lg2_due.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
		if (lg2_due.size() != 0)
			flag($sformatf("%0d results never arrived", lg2_due.size()));

		$display("covered %0d operands over %0d frac_bits writes, %0d results compared",
			in_count, fmt_writes, out_count);
		$display("sentinels, saturated formats, one-below-minimum, rounding carry; %0d mismatches",
			miss_cnt);
		if (miss_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
